[hdl/ohlc_pkg.sv]
`default_nettype none

package ohlc_pkg;

    localparam int unsigned FieldW = 63;
    localparam int unsigned SecW   = 25;
    localparam int unsigned DivW   = 35;
    localparam int unsigned AluW   = 64;
    localparam int unsigned CntW   = 6;
    localparam int unsigned DataW  = 320;
    localparam int unsigned AddrW  = 3;
    localparam int unsigned PadW   = DataW - 5 * FieldW;

    localparam logic [SecW-1:0] SecReset = SecW'(3600);
    localparam logic [CntW-1:0] DivLast  = CntW'(FieldW - 1);
    localparam logic [CntW-1:0] MulLast  = CntW'(DivW - 1);

    // Register index as carried in paddr above the byte offset.
    localparam logic RegBarSeconds = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_MUL,
        ST_EMIT,
        ST_APPLY
    } t_state;

    typedef enum logic [1:0] {
        ALU_DIV,
        ALU_MUL,
        ALU_STAMP
    } t_alu_sel;

    function automatic logic [SecW-1:0] eff_seconds(input logic [SecW-1:0] sec);
        return (sec == '0) ? SecW'(1) : sec;
    endfunction

    // Bar length in milliseconds: sec * 1000 = sec * (1024 - 32 + 8).
    function automatic logic [DivW-1:0] ms_divisor(input logic [SecW-1:0] sec);
        logic [DivW-1:0] e;
        e = DivW'(eff_seconds(sec));
        return (e << 10) - (e << 5) + (e << 3);
    endfunction

endpackage

`default_nettype wire

[hdl/ohlc_bar_aggregator.sv]
// OHLC bar aggregator.
// Source bars arrive on the s_axis request channel (tuser = 0) and are merged
// into bars whose length in seconds is set by the bar_seconds register at
// APB address 0. A request with tuser = 1 flushes the open bar. Finished bars
// leave on the m_axis channel, one request per finished bar with a nonzero open.
// A source bar passes the bucket division in the shared 64-bit add/subtract
// unit (one quotient bit per cycle), a decision state, a state that loads the
// output register when a bar is emitted and an update state, after which
// s_axis_tready is high again. If bar_seconds changed while the emitted bar was
// open, its start time is recomputed by shift-and-add in the same unit before
// the load. A flush goes straight to the decision state. The emitted bar is
// valid on m_axis from the edge that ends the load state. The output register
// lets the block accept and divide the next source bar while a result waits;
// when the receiver stalls, the block waits before loading the next result.
// Reset restores bar_seconds to 3600, closes the open bar and empties the
// output register.
`default_nettype none

module ohlc_bar_aggregator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ohlc_pkg::AddrW-1:0]        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0: time_ms, open_price, high_price, low_price, close_price.
    input  wire logic [ohlc_pkg::DataW-1:0]        s_axis_tdata,
    // Field: opcode.
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // Fields from bit 0: bucket_start_ms, bar_open, bar_high, bar_low, bar_close.
    output logic      [ohlc_pkg::DataW-1:0]        m_axis_tdata
);

    localparam int unsigned FW = ohlc_pkg::FieldW;
    localparam int unsigned SW = ohlc_pkg::SecW;
    localparam int unsigned DW = ohlc_pkg::DivW;
    localparam int unsigned AW = ohlc_pkg::AluW;
    localparam int unsigned CW = ohlc_pkg::CntW;

    ohlc_pkg::t_state   r_state, n_state;
    ohlc_pkg::t_alu_sel alu_sel;

    logic [SW-1:0] r_sec;
    logic          r_opcode;
    logic [FW-1:0] r_t, r_o, r_h, r_l, r_c;
    logic          r_active;
    logic [FW-1:0] r_index;
    logic [FW-1:0] r_run_open, r_run_high, r_run_low, r_run_close;
    logic [FW-1:0] r_stamp;
    logic [SW-1:0] r_stamp_sec;
    logic [DW-1:0] r_rem;
    logic [FW-1:0] r_quo;
    logic [FW-1:0] r_acc;
    logic [FW-1:0] r_mcand;
    logic [DW-1:0] r_mplier;
    logic [CW-1:0] r_cnt;
    logic          r_out_valid;
    logic [ohlc_pkg::DataW-1:0] r_out_data;

    logic          in_accept;
    logic          out_load;
    logic          cfg_write;
    logic          reg_hit;
    logic [SW-1:0] eff_sec;
    logic [DW-1:0] divisor;
    logic          new_bar;
    logic          do_emit;
    logic          fast_stamp;
    logic [AW-1:0] alu_a, alu_b;
    logic          alu_sub;
    logic [AW:0]   alu_sum;
    logic          no_borrow;

    assign eff_sec    = ohlc_pkg::eff_seconds(r_sec);
    assign divisor    = ohlc_pkg::ms_divisor(r_sec);
    assign new_bar    = !r_opcode && (!r_active || (r_quo != r_index));
    assign do_emit    = r_active && (r_run_open != '0) && (r_opcode || new_bar);
    assign fast_stamp = (r_stamp_sec == eff_sec);

    assign reg_hit   = (paddr[ohlc_pkg::AddrW-1] == ohlc_pkg::RegBarSeconds);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = reg_hit ? 32'(r_sec) : '0;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The one shared add/subtract unit.
    always_comb begin
        unique case (alu_sel)
            ohlc_pkg::ALU_DIV: begin
                alu_a   = AW'({r_rem, r_quo[FW-1]});
                alu_b   = AW'(divisor);
                alu_sub = 1'b1;
            end
            ohlc_pkg::ALU_MUL: begin
                alu_a   = AW'(r_acc);
                alu_b   = AW'(r_mcand);
                alu_sub = 1'b0;
            end
            ohlc_pkg::ALU_STAMP: begin
                alu_a   = AW'(r_t);
                alu_b   = AW'(r_rem);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
        alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
        no_borrow = alu_sum[AW];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ohlc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = s_axis_tuser ? ohlc_pkg::ST_EVAL : ohlc_pkg::ST_DIV;
                end
            end
            ohlc_pkg::ST_DIV: begin
                if (r_cnt == ohlc_pkg::DivLast) begin
                    n_state = ohlc_pkg::ST_EVAL;
                end
            end
            ohlc_pkg::ST_EVAL: begin
                if (!do_emit) begin
                    n_state = ohlc_pkg::ST_APPLY;
                end else if (fast_stamp) begin
                    n_state = ohlc_pkg::ST_EMIT;
                end else begin
                    n_state = ohlc_pkg::ST_MUL;
                end
            end
            ohlc_pkg::ST_MUL: begin
                if (r_cnt == ohlc_pkg::MulLast) begin
                    n_state = ohlc_pkg::ST_EMIT;
                end
            end
            ohlc_pkg::ST_EMIT: begin
                if (out_load) begin
                    n_state = ohlc_pkg::ST_APPLY;
                end
            end
            ohlc_pkg::ST_APPLY: begin
                n_state = ohlc_pkg::ST_IDLE;
            end
            default: begin
                n_state = ohlc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ohlc_pkg::ST_IDLE);
        in_accept     = s_axis_tvalid && s_axis_tready;
        out_load      = (r_state == ohlc_pkg::ST_EMIT) && (!r_out_valid || m_axis_tready);
        unique case (r_state)
            ohlc_pkg::ST_MUL:   alu_sel = ohlc_pkg::ALU_MUL;
            ohlc_pkg::ST_APPLY: alu_sel = ohlc_pkg::ALU_STAMP;
            default:            alu_sel = ohlc_pkg::ALU_DIV;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ohlc_pkg::ST_IDLE;
            r_sec       <= ohlc_pkg::SecReset;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_write && reg_hit) begin
                r_sec <= pwdata[SW-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ohlc_pkg::ST_APPLY) begin
                if (r_opcode) begin
                    r_active <= 1'b0;
                end else if (new_bar) begin
                    r_active <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ohlc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    r_opcode <= s_axis_tuser;
                    r_t      <= s_axis_tdata[FW-1:0];
                    r_o      <= s_axis_tdata[2*FW-1:FW];
                    r_h      <= s_axis_tdata[3*FW-1:2*FW];
                    r_l      <= s_axis_tdata[4*FW-1:3*FW];
                    r_c      <= s_axis_tdata[5*FW-1:4*FW];
                    r_rem    <= '0;
                    r_quo    <= s_axis_tdata[FW-1:0];
                    r_cnt    <= '0;
                end
            end
            ohlc_pkg::ST_DIV: begin
                if (no_borrow) begin
                    r_rem <= alu_sum[DW-1:0];
                end else begin
                    r_rem <= {r_rem[DW-2:0], r_quo[FW-1]};
                end
                r_quo <= {r_quo[FW-2:0], no_borrow};
                r_cnt <= r_cnt + CW'(1);
            end
            ohlc_pkg::ST_EVAL: begin
                if (fast_stamp) begin
                    r_acc <= r_stamp;
                end else begin
                    r_acc <= '0;
                end
                r_mcand  <= r_index;
                r_mplier <= divisor;
                r_cnt    <= '0;
            end
            ohlc_pkg::ST_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= alu_sum[FW-1:0];
                end
                r_mcand  <= {r_mcand[FW-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[DW-1:1]};
                r_cnt    <= r_cnt + CW'(1);
            end
            ohlc_pkg::ST_EMIT: begin
                if (out_load) begin
                    r_out_data <= {{ohlc_pkg::PadW{1'b0}}, r_run_close, r_run_low,
                                   r_run_high, r_run_open, r_acc};
                end
            end
            ohlc_pkg::ST_APPLY: begin
                if (!r_opcode) begin
                    if (new_bar) begin
                        r_index     <= r_quo;
                        r_run_open  <= r_o;
                        r_run_high  <= r_h;
                        r_run_low   <= r_l;
                        r_run_close <= r_c;
                        r_stamp     <= alu_sum[FW-1:0];
                        r_stamp_sec <= eff_sec;
                    end else begin
                        if (r_h > r_run_high) begin
                            r_run_high <= r_h;
                        end
                        if (r_l < r_run_low) begin
                            r_run_low <= r_l;
                        end
                        r_run_close <= r_c;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/ohlc_chk.sv]
`default_nettype none

module ohlc_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [ohlc_pkg::DataW-1:0] m_axis_tdata
);

    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_stall_holds_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input ready too soon after a request");

    a_new_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !s_axis_tready)
        else $error("result appeared while the block was idle");

endmodule

bind ohlc_bar_aggregator ohlc_chk u_ohlc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
